@@ hw/rtl/stns_pkg.sv @@
// ----------------------------------------------------------------------------
// stns_pkg
// Shared types and constants for the socket table nearest search block.
// ----------------------------------------------------------------------------
package stns_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int COORD_W = 24;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W = 2 * DIFF_W;
    localparam int D2_W = SQ_W + 2;
    localparam int RAD_W = 23;

    typedef enum logic [1:0]
    {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_CLEAR      = 2'd2,
        CMD_FIND       = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed
    {
        logic [15:0]        id;
        logic [7:0]         typ;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/stns_ram.sv @@
// ----------------------------------------------------------------------------
// stns_ram
// Single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module stns_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/socket_table_nearest_search_top.sv @@
// ----------------------------------------------------------------------------
// socket_table_nearest_search_top
// Ordered socket point table with append, remove by id, clear, nearest find.
// ----------------------------------------------------------------------------
// One word is worked at a time. Register and clear load the result register
// at the accepting edge, so the result is offered on the next cycle and a new
// word can be taken while that result is being read. Unregister and find
// stream the table through the single read port of the entry RAM, one entry
// per cycle; their result is registered once the scan is done, the pipe is
// empty and the output register is free. Find distances go through a two
// stage pipe (difference, then squares and sum). Unregister compacts in
// place: the write pointer never passes the read pointer, so no forwarding
// is needed. A new word is taken only when the block is idle and the output
// register is empty or is being read in the same cycle.
module socket_table_nearest_search_top
    import stns_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // command[1:0], socket_id[17:2], socket_type[25:18], match_any[26],
    // pos_x[50:27], pos_y[74:51], pos_z[98:75], snap_radius[121:99], zero fill
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], found_id[17:2], found_type[25:18], found_x[49:26],
    // found_y[73:50], found_z[97:74], zero fill
    output logic [103:0] m_tdata
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_HOLD
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] wr_ptr_reg;
    logic             rd_vld_reg;
    cmd_t             cmd_reg;
    logic [15:0]      q_id_reg;
    logic [7:0]       q_type_reg;
    logic             q_any_reg;
    logic signed [COORD_W-1:0] q_x_reg, q_y_reg, q_z_reg;
    logic [D2_W-1:0]  bound_reg;
    logic             hit_reg;
    entry_t           best_reg;

    // find pipe stage 1
    logic             p1_vld_reg;
    entry_t           p1_ent_reg;
    logic [DIFF_W-1:0] p1_dx_reg, p1_dy_reg, p1_dz_reg;
    // find pipe stage 2
    logic             p2_vld_reg;
    entry_t           p2_ent_reg;
    logic [D2_W-1:0]  p2_d2_reg;

    logic             out_vld_reg;
    logic [103:0]     out_data_reg;

    // radius squared pipeline helper
    logic [2*RAD_W-1:0] rad_sq_reg;

    // RAM port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t           rd_ent;

    logic accept;
    logic out_free;

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata = out_data_reg;
    assign rd_ent = entry_t'(ram_rdata);

    stns_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [DIFF_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                   logic [COORD_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    function automatic logic [103:0] pack_out(logic [1:0] st, entry_t e);
        return {6'd0, e.z, e.y, e.x, e.typ, e.id, st};
    endfunction

    // accepted entry from the RAM this cycle (unregister keeps, find tests)
    logic keep;
    logic type_ok;
    assign keep = rd_vld_reg && (rd_ent.id != q_id_reg);
    assign type_ok = q_any_reg || (rd_ent.typ == q_type_reg);

    // scan finished, pipe empty and output free, result can be loaded
    logic drain_done;
    logic out_load;
    assign drain_done = (state_reg == S_DRAIN) && !rd_vld_reg && !p1_vld_reg
                        && !p2_vld_reg && out_free;
    assign out_load = (accept && (s_tdata[1:0] inside {CMD_REGISTER, CMD_CLEAR}))
                      || drain_done;

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = wr_ptr_reg[IDX_W-1:0];
        ram_wdata = rd_ent;
        ram_raddr = rd_ptr_reg[IDX_W-1:0];
        if (accept && cmd_t'(s_tdata[1:0]) == CMD_REGISTER
            && count_reg != CNT_W'(TABLE_DEPTH))
        begin
            ram_we = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata.id = s_tdata[17:2];
            ram_wdata.typ = s_tdata[25:18];
            ram_wdata.x = s_tdata[50:27];
            ram_wdata.y = s_tdata[74:51];
            ram_wdata.z = s_tdata[98:75];
        end
        else if (cmd_reg == CMD_UNREGISTER && keep && state_reg != S_IDLE)
        begin
            ram_we = 1'b1;
        end
    end

    logic [2*RAD_W-1:0] rad_sq;
    assign rad_sq = (2*RAD_W)'(s_tdata[121:99]) * (2*RAD_W)'(s_tdata[121:99]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            rd_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            hit_reg <= 1'b0;
            cmd_reg <= CMD_CLEAR;
        end
        else
        begin
            out_vld_reg <= out_load || (out_vld_reg && !m_tready);
            rd_vld_reg <= (state_reg == S_SCAN) && (rd_ptr_reg < count_reg);
            p1_vld_reg <= (cmd_reg == CMD_FIND) && rd_vld_reg && type_ok;
            p2_vld_reg <= p1_vld_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= cmd_t'(s_tdata[1:0]);
                        q_id_reg <= s_tdata[17:2];
                        q_type_reg <= s_tdata[25:18];
                        q_any_reg <= s_tdata[26];
                        q_x_reg <= s_tdata[50:27];
                        q_y_reg <= s_tdata[74:51];
                        q_z_reg <= s_tdata[98:75];
                        rad_sq_reg <= rad_sq;
                        rd_ptr_reg <= '0;
                        wr_ptr_reg <= '0;
                        hit_reg <= 1'b0;
                        case (cmd_t'(s_tdata[1:0]))
                            CMD_REGISTER:
                            begin
                                if (count_reg == CNT_W'(TABLE_DEPTH))
                                begin
                                    out_data_reg <= pack_out(ST_FULL, '0);
                                end
                                else
                                begin
                                    out_data_reg <= pack_out(ST_OK, '0);
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                out_data_reg <= pack_out(ST_OK, '0);
                                count_reg <= '0;
                            end
                            default:
                            begin
                                state_reg <= S_HOLD;
                            end
                        endcase
                    end
                end
                S_HOLD:
                begin
                    // load bound once radius square is registered
                    bound_reg <= D2_W'(rad_sq_reg) + D2_W'(65536);
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (rd_ptr_reg < count_reg)
                    begin
                        rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (drain_done)
                    begin
                        state_reg <= S_IDLE;
                        if (cmd_reg == CMD_UNREGISTER)
                        begin
                            count_reg <= wr_ptr_reg;
                            out_data_reg <= pack_out(ST_OK, '0);
                        end
                        else if (hit_reg)
                        begin
                            out_data_reg <= pack_out(ST_OK, best_reg);
                        end
                        else
                        begin
                            out_data_reg <= pack_out(ST_NONE, '0);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cmd_reg == CMD_UNREGISTER && keep && state_reg != S_IDLE)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (p2_vld_reg && p2_d2_reg < bound_reg)
            begin
                bound_reg <= p2_d2_reg;
                best_reg <= p2_ent_reg;
                hit_reg <= 1'b1;
            end
        end
    end

    // full width squares of the stage 1 differences
    logic [SQ_W-1:0] sq_x, sq_y, sq_z;
    assign sq_x = p1_dx_reg * p1_dx_reg;
    assign sq_y = p1_dy_reg * p1_dy_reg;
    assign sq_z = p1_dz_reg * p1_dz_reg;

    // find datapath, no reset
    always_ff @(posedge clk)
    begin
        p1_ent_reg <= rd_ent;
        p1_dx_reg <= abs_diff(rd_ent.x, q_x_reg);
        p1_dy_reg <= abs_diff(rd_ent.y, q_y_reg);
        p1_dz_reg <= abs_diff(rd_ent.z, q_z_reg);
        p2_ent_reg <= p1_ent_reg;
        p2_d2_reg <= D2_W'(sq_x) + D2_W'(sq_y) + D2_W'(sq_z);
    end

endmodule

@@ hw/rtl/stns_checker.sv @@
// ----------------------------------------------------------------------------
// stns_checker
// Port level checks for the socket table nearest search block.
// ----------------------------------------------------------------------------
module stns_checker
    import stns_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [127:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // a result stalled by the sink holds its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // status is never the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad status");

    // a result whose status is not OK carries zero payload
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[103:2] == '0)
        else $error("payload not zero");

    // a taken clear is answered by an OK status result from the result register
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[1:0] == CMD_CLEAR
        |=> m_tvalid && m_tdata[1:0] == ST_OK)
        else $error("clear result missing");

endmodule

bind socket_table_nearest_search_top stns_checker u_stns_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket table nearest search testbench
// Drives register, unregister, clear and find words into the block, predicts
// each result with a local copy of the point table and compares every result
// word, in order, against the oldest predicted one, reporting field by field.
// ----------------------------------------------------------------------------

// Scoreboard: holds the predicted table and the queue of predicted results.
class nearest_scoreboard;
    logic [15:0]  tbl_id [stns_pkg::TABLE_DEPTH];
    logic [7:0]   tbl_typ [stns_pkg::TABLE_DEPTH];
    logic [23:0]  tbl_x [stns_pkg::TABLE_DEPTH];
    logic [23:0]  tbl_y [stns_pkg::TABLE_DEPTH];
    logic [23:0]  tbl_z [stns_pkg::TABLE_DEPTH];
    int           count;
    logic [103:0] pending_results [$];
    int           mismatches;

    function longint unsigned sq_dist(logic [23:0] a, logic [23:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return longint'(d * d);
    endfunction

    // Predict the result of one accepted command word.
    function void note_command(logic [127:0] w);
        stns_pkg::cmd_t cmd;
        logic [15:0] id;
        logic [7:0] typ;
        logic any;
        logic [23:0] px, py, pz;
        logic [22:0] rad;
        logic [1:0] st;
        logic [103:0] res;
        longint unsigned bound, d2;
        int best, wr;
        bit hit;
        cmd = stns_pkg::cmd_t'(w[1:0]);
        id = w[17:2];
        typ = w[25:18];
        any = w[26];
        px = w[50:27];
        py = w[74:51];
        pz = w[98:75];
        rad = w[121:99];
        res = '0;
        st = stns_pkg::ST_OK;
        case (cmd)
            stns_pkg::CMD_REGISTER:
            begin
                if (count >= stns_pkg::TABLE_DEPTH)
                    st = stns_pkg::ST_FULL;
                else
                begin
                    tbl_id[count] = id;
                    tbl_typ[count] = typ;
                    tbl_x[count] = px;
                    tbl_y[count] = py;
                    tbl_z[count] = pz;
                    count++;
                end
            end
            stns_pkg::CMD_UNREGISTER:
            begin
                wr = 0;
                for (int i = 0; i < count; i++)
                begin
                    if (tbl_id[i] != id)
                    begin
                        tbl_id[wr] = tbl_id[i];
                        tbl_typ[wr] = tbl_typ[i];
                        tbl_x[wr] = tbl_x[i];
                        tbl_y[wr] = tbl_y[i];
                        tbl_z[wr] = tbl_z[i];
                        wr++;
                    end
                end
                count = wr;
            end
            stns_pkg::CMD_CLEAR:
                count = 0;
            default:
            begin
                bound = longint'(rad) * longint'(rad) + 65536;
                hit = 0;
                best = 0;
                for (int i = 0; i < count; i++)
                begin
                    if (any || tbl_typ[i] == typ)
                    begin
                        d2 = sq_dist(tbl_x[i], px) + sq_dist(tbl_y[i], py)
                           + sq_dist(tbl_z[i], pz);
                        if (d2 < bound)
                        begin
                            bound = d2;
                            best = i;
                            hit = 1;
                        end
                    end
                end
                if (!hit)
                    st = stns_pkg::ST_NONE;
                else
                    res[97:2] = {tbl_z[best], tbl_y[best], tbl_x[best],
                                 tbl_typ[best], tbl_id[best]};
            end
        endcase
        res[1:0] = st;
        pending_results.insert(pending_results.size(), res);
    endfunction

    function void check_result(logic [103:0] got);
        logic [103:0] exp;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result word %h", got);
            return;
        end
        exp = pending_results.pop_front();
        if (got !== exp)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: st %0d/%0d id %h/%h typ %h/%h x %h/%h y %h/%h z %h/%h",
                         exp[1:0], got[1:0], exp[17:2], got[17:2], exp[25:18],
                         got[25:18], exp[49:26], got[49:26], exp[73:50],
                         got[73:50], exp[97:74], got[97:74]);
        end
    endfunction
endclass

module testbench;
    import stns_pkg::*;

    localparam int N_RANDOM = 530;
    localparam int CYCLE_LIMIT = 400000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    nearest_scoreboard sb = new();
    bit  quiet_phase = 0;     // last part of the run: no idling
    bit  hold_sink = 0;       // long receiver hold-off request
    int  cycles = 0;

    // small pools keep ids and types colliding often
    logic [15:0] id_pool [8];
    logic [7:0]  typ_pool [4];

    always #5 clk = ~clk;

    socket_table_nearest_search_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Cycle limit guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Monitor: score every accepted word on both sides.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_command(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: random stall bursts, one long hold-off when asked.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                for (n = 0; n < 600; n++)
                    @(posedge clk);
                hold_sink = 0;
                m_tready <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom);
            default: return 24'($signed(10'($urandom)));  // clustered near 0
        endcase
    endfunction

    function automatic logic [127:0] make_word(cmd_t cmd, logic [15:0] id,
                                               logic [7:0] typ, logic any,
                                               logic [23:0] x, logic [23:0] y,
                                               logic [23:0] z, logic [22:0] r);
        logic [127:0] w;
        w = '0;
        w[121:0] = {r, z, y, x, any, typ, id, cmd};
        return w;
    endfunction

    // Offer one word and wait for it to be taken; valid stays high across
    // back-to-back words.
    task automatic send_word(logic [127:0] w);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int sel;
        cmd_t cmd;
        logic [22:0] r;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            cmd = CMD_REGISTER;
        else if (sel < 60)
            cmd = CMD_UNREGISTER;
        else if (sel < 63)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_FIND;
        case ($urandom_range(0, 3))
            0: r = 23'($urandom);
            1: r = 23'h7FFFFF;
            2: r = '0;
            default: r = 23'($urandom_range(0, 4096));
        endcase
        send_word(make_word(cmd,
                            $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                      : id_pool[$urandom_range(0, 7)],
                            $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                      : typ_pool[$urandom_range(0, 3)],
                            1'($urandom), rand_coord(), rand_coord(), rand_coord(), r));
    endtask

    initial
    begin
        foreach (id_pool[i])
            id_pool[i] = 16'($urandom);
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        foreach (typ_pool[i])
            typ_pool[i] = 8'($urandom);
        typ_pool[0] = 8'h00;
        typ_pool[1] = 8'hFF;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty find, extremes, tie, typed find, unregister, clear.
        send_word(make_word(CMD_FIND, 0, 0, 1, 0, 0, 0, 23'h7FFFFF));
        send_word(make_word(CMD_UNREGISTER, 16'h1234, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_REGISTER, 16'hFFFF, 8'hFF, 0,
                            24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0));
        send_word(make_word(CMD_REGISTER, 16'h0000, 8'h00, 0,
                            24'h800000, 24'h800000, 24'h800000, 0));
        send_word(make_word(CMD_REGISTER, 16'h0001, 8'h01, 0, 24'h100, 0, 0, 0));
        send_word(make_word(CMD_REGISTER, 16'h0002, 8'h01, 0, 24'hFFFF00, 0, 0, 0));
        // tie between the last two: earliest wins
        send_word(make_word(CMD_FIND, 0, 8'h01, 0, 0, 0, 0, 23'h000200));
        // radius zero: only points closer than 256 units
        send_word(make_word(CMD_FIND, 0, 0, 1, 24'h000001, 0, 0, 0));
        send_word(make_word(CMD_FIND, 0, 8'hFF, 0, 24'h800000, 24'h800000,
                            24'h800000, 23'h7FFFFF));
        send_word(make_word(CMD_FIND, 0, 0, 1, 24'h800000, 24'h800000,
                            24'h800000, 23'h7FFFFF));
        send_word(make_word(CMD_FIND, 0, 8'h7E, 0, 0, 0, 0, 23'h7FFFFF));
        send_word(make_word(CMD_UNREGISTER, 16'h0001, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_FIND, 0, 8'h01, 0, 0, 0, 0, 23'h000200));
        // fill to full, then one more register
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            send_word(make_word(CMD_REGISTER, 16'h0005, 8'($urandom), 1'($urandom),
                                rand_coord(), rand_coord(), rand_coord(), 23'($urandom)));
        send_word(make_word(CMD_REGISTER, 16'h0006, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_FIND, 0, 0, 1, 0, 0, 0, 23'h7FFFFF));
        send_word(make_word(CMD_UNREGISTER, 16'h0005, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_FIND, 0, 0, 1, 0, 0, 0, 23'h7FFFFF));

        // Back-pressure: receiver holds off while the sender keeps offering.
        hold_sink = 1;
        for (int i = 0; i < 40; i++)
            send_random();
        // Sender pauses until everything has come out.
        stop_sending();
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM - 100)
                quiet_phase = 1;
            send_random();
        end
        stop_sending();

        wait_drained();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
